// File: hdl/gcmi_pkg.sv
`default_nettype none
package gcmi_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;
  localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 24;
  localparam int FRAC_W = 12;
  localparam int DIST_W = 31;
  localparam int CELL_W = 7;
  localparam int CFG_AW = 5;

  // register indexes (word address)
  localparam logic [2:0] REG_KIND    = 3'd0;
  localparam logic [2:0] REG_LEVEL   = 3'd1;
  localparam logic [2:0] REG_STAGGER = 3'd2;
  localparam logic [2:0] REG_CELLS_X = 3'd3;
  localparam logic [2:0] REG_CELLS_Y = 3'd4;
  localparam logic [2:0] REG_CELLS_Z = 3'd5;

  // staggering codes
  localparam logic [2:0] STG_CENTER = 3'd0;
  localparam logic [2:0] STG_XFACE  = 3'd1;
  localparam logic [2:0] STG_YFACE  = 3'd2;
  localparam logic [2:0] STG_ZFACE  = 3'd3;
  localparam logic [2:0] STG_CORNER = 3'd4;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_CORRECT = 1'b1;

  localparam logic KIND_DIRICHLET = 1'b0;
  localparam logic KIND_NEUMANN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WRS, ST_IDX, ST_READ, ST_LERP, ST_FIN, ST_DONE
  } state_t;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] level;
    logic [2:0]               stagger;
    logic [CELL_W-1:0]        cells_x;
    logic [CELL_W-1:0]        cells_y;
    logic [CELL_W-1:0]        cells_z;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       wr_sample;
    logic       calc_idx;
    logic       rd_issue;
    logic [2:0] corner;
    logic       capture;
    logic       lerp_en;
    logic [2:0] step;
    logic       final_en;
    logic       wr_ghost;
    logic       push_out;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/gcmi_in_if.sv
`default_nettype none
interface gcmi_in_if;
  import gcmi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         index_x;
  logic [IDX_W-1:0]         index_y;
  logic [IDX_W-1:0]         index_z;
  logic signed [DATA_W-1:0] sample;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [DIST_W-1:0]        distance;
  modport source (output valid, mode, index_x, index_y, index_z, sample,
                  pos_x, pos_y, pos_z, distance, input ready);
  modport sink (input valid, mode, index_x, index_y, index_z, sample,
                pos_x, pos_y, pos_z, distance, output ready);
endinterface
`default_nettype wire

// File: hdl/gcmi_out_if.sv
`default_nettype none
interface gcmi_out_if;
  import gcmi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] ghost_value;
  logic signed [DATA_W-1:0] mirror_value;
  modport source (output valid, ghost_value, mirror_value, input ready);
  modport sink (input valid, ghost_value, mirror_value, output ready);
endinterface
`default_nettype wire

// File: hdl/gcmi_ram.sv
`default_nettype none
module gcmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/gcmi_cfg.sv
`default_nettype none
module gcmi_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [gcmi_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output gcmi_pkg::cfg_t             cfg
);
  import gcmi_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] widx;

  assign widx   = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (widx)
        REG_KIND:    cfg_nxt.kind    = pwdata[0];
        REG_LEVEL:   cfg_nxt.level   = pwdata;
        REG_STAGGER: cfg_nxt.stagger = pwdata[2:0];
        REG_CELLS_X: cfg_nxt.cells_x = pwdata[CELL_W-1:0];
        REG_CELLS_Y: cfg_nxt.cells_y = pwdata[CELL_W-1:0];
        REG_CELLS_Z: cfg_nxt.cells_z = pwdata[CELL_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_KIND:    prdata = {31'd0, cfg_r.kind};
      REG_LEVEL:   prdata = cfg_r.level;
      REG_STAGGER: prdata = {29'd0, cfg_r.stagger};
      REG_CELLS_X: prdata = {{(32-CELL_W){1'b0}}, cfg_r.cells_x};
      REG_CELLS_Y: prdata = {{(32-CELL_W){1'b0}}, cfg_r.cells_y};
      REG_CELLS_Z: prdata = {{(32-CELL_W){1'b0}}, cfg_r.cells_z};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind    <= KIND_DIRICHLET;
      cfg_r.level   <= '0;
      cfg_r.stagger <= STG_CENTER;
      cfg_r.cells_x <= CELL_W'(64);
      cfg_r.cells_y <= CELL_W'(64);
      cfg_r.cells_z <= CELL_W'(64);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hdl/gcmi_ctrl.sv
`default_nettype none
module gcmi_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output gcmi_pkg::cmd_t  cmd
);
  import gcmi_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = (in_mode == MODE_CORRECT) ? ST_IDX : ST_WRS;
        end
      end
      ST_WRS: begin
        cmd.wr_sample = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_IDX: begin
        cmd.calc_idx = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_READ;
      end
      ST_READ: begin
        // issue eight corner reads, capture each read result in the next cycle
        cmd.rd_issue = !cnt_r[3];
        cmd.corner   = cnt_r[2:0];
        cmd.capture  = (cnt_r != 4'd0);
        if (cnt_r == 4'd8) begin
          cnt_nxt   = '0;
          state_nxt = ST_LERP;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_LERP: begin
        cmd.lerp_en = 1'b1;
        cmd.step    = cnt_r[2:0];
        if (cnt_r == 4'd6) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_FIN: begin
        cmd.final_en = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.wr_ghost = 1'b1;
          cmd.push_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.push_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hdl/gcmi_dp.sv
`default_nettype none
module gcmi_dp (
  input  wire logic                            clk,
  input  wire gcmi_pkg::cmd_t                  cmd,
  input  wire gcmi_pkg::cfg_t                  cfg,
  input  wire logic [gcmi_pkg::IDX_W-1:0]      in_index_x,
  input  wire logic [gcmi_pkg::IDX_W-1:0]      in_index_y,
  input  wire logic [gcmi_pkg::IDX_W-1:0]      in_index_z,
  input  wire logic signed [gcmi_pkg::DATA_W-1:0] in_sample,
  input  wire logic signed [gcmi_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [gcmi_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [gcmi_pkg::POS_W-1:0]  in_pos_z,
  input  wire logic [gcmi_pkg::DIST_W-1:0]     in_distance,
  output logic                                 ram_we,
  output logic [gcmi_pkg::ADDR_W-1:0]          ram_waddr,
  output logic [gcmi_pkg::DATA_W-1:0]          ram_wdata,
  output logic                                 ram_re,
  output logic [gcmi_pkg::ADDR_W-1:0]          ram_raddr,
  input  wire logic [gcmi_pkg::DATA_W-1:0]     ram_rdata,
  output logic signed [gcmi_pkg::DATA_W-1:0]   out_ghost_value,
  output logic signed [gcmi_pkg::DATA_W-1:0]   out_mirror_value
);
  import gcmi_pkg::*;

  localparam int G_W = POS_W + 1;
  localparam int I_W = G_W - FRAC_W + 1;

  function automatic logic [CELL_W-1:0] size_in_use(input logic [CELL_W-1:0] r,
                                                     input int grid);
    logic [CELL_W-1:0] n;
    n = r;
    if (r == '0) n = CELL_W'(1);
    if ({1'b0, r} > (CELL_W+1)'(grid)) n = CELL_W'(grid);
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [I_W-1:0] i,
                                                 input logic [CELL_W-1:0] n);
    logic [IDX_W-1:0] c;
    logic [CELL_W-1:0] top;
    top = n - CELL_W'(1);
    if (i < 0) begin
      c = '0;
    end else if (i > $signed({{(I_W-CELL_W){1'b0}}, top})) begin
      c = top[IDX_W-1:0];
    end else begin
      c = i[IDX_W-1:0];
    end
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y,
                                                  input logic [IDX_W-1:0] z);
    return ADDR_W'(z) * ADDR_W'(GRID_X * GRID_Y) + ADDR_W'(y) * ADDR_W'(GRID_X)
           + ADDR_W'(x);
  endfunction

  // latched item
  logic [IDX_W-1:0]         ix_r, iy_r, iz_r;
  logic signed [DATA_W-1:0] sample_r;
  logic signed [POS_W-1:0]  mx_r, my_r, mz_r;
  logic [DIST_W-1:0]        dist_r;

  // corner indexes and fractions
  logic [IDX_W-1:0]  x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [FRAC_W-1:0] sx_r, sy_r, sz_r;
  logic signed [63:0] prod_r;

  logic signed [DATA_W-1:0] cq_r [8];
  logic signed [DATA_W-1:0] vq_r [4];
  logic signed [DATA_W-1:0] dq_r [2];
  logic signed [DATA_W-1:0] mirror_r, ghost_r;
  logic signed [DATA_W-1:0] out_ghost_r, out_mirror_r;

  logic hx, hy, hz;
  logic signed [G_W-1:0] gx, gy, gz;
  logic signed [I_W-1:0] ix0, iy0, iz0;
  logic [CELL_W-1:0] nx, ny, nz;

  assign hx = !(cfg.stagger == STG_XFACE || cfg.stagger == STG_CORNER);
  assign hy = !(cfg.stagger == STG_YFACE || cfg.stagger == STG_CORNER);
  assign hz = !(cfg.stagger == STG_ZFACE || cfg.stagger == STG_CORNER);

  assign gx = G_W'(mx_r) - (hx ? G_W'(2048) : G_W'(0));
  assign gy = G_W'(my_r) - (hy ? G_W'(2048) : G_W'(0));
  assign gz = G_W'(mz_r) - (hz ? G_W'(2048) : G_W'(0));

  // floor of the position: keep the sign of the integer part
  assign ix0 = I_W'($signed(gx[G_W-1:FRAC_W]));
  assign iy0 = I_W'($signed(gy[G_W-1:FRAC_W]));
  assign iz0 = I_W'($signed(gz[G_W-1:FRAC_W]));

  assign nx = size_in_use(cfg.cells_x, GRID_X);
  assign ny = size_in_use(cfg.cells_y, GRID_Y);
  assign nz = size_in_use(cfg.cells_z, GRID_Z);

  // shared interpolation unit: a + (b - a) * s, rounded
  logic signed [DATA_W-1:0] la, lb, lres;
  logic [FRAC_W-1:0]        ls;
  logic signed [DATA_W:0]   ldiff;
  logic signed [DATA_W+FRAC_W+2:0] lsum;

  always_comb begin
    if (cmd.step < 3'd4) begin
      la = cq_r[0]; lb = cq_r[1]; ls = sx_r;
    end else if (cmd.step < 3'd6) begin
      la = vq_r[0]; lb = vq_r[1]; ls = sy_r;
    end else begin
      la = dq_r[0]; lb = dq_r[1]; ls = sz_r;
    end
    ldiff = (DATA_W+1)'(lb) - (DATA_W+1)'(la);
    lsum  = ((DATA_W+FRAC_W+3)'(la) <<< FRAC_W)
          + (DATA_W+FRAC_W+3)'(ldiff * $signed({1'b0, ls}))
          + (DATA_W+FRAC_W+3)'(2048);
    lres  = lsum[DATA_W+FRAC_W-1:FRAC_W];
  end

  // boundary rule with saturation
  logic signed [47:0] rnd;
  logic signed [48:0] gpre;
  logic signed [DATA_W-1:0] gsat;

  always_comb begin
    rnd = 48'((prod_r + 64'sd32768) >>> 16);
    if (cfg.kind == KIND_NEUMANN) begin
      gpre = 49'(mirror_r) - 49'(rnd);
    end else begin
      gpre = (49'(cfg.level) <<< 1) - 49'(mirror_r);
    end
    if (gpre > 49'sd2147483647) begin
      gsat = 32'sh7FFFFFFF;
    end else if (gpre < -49'sd2147483648) begin
      gsat = 32'sh80000000;
    end else begin
      gsat = gpre[DATA_W-1:0];
    end
  end

  assign ram_we    = cmd.wr_sample | cmd.wr_ghost;
  assign ram_waddr = grid_addr(ix_r, iy_r, iz_r);
  assign ram_wdata = cmd.wr_sample ? sample_r : ghost_r;
  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = grid_addr(cmd.corner[0] ? x1_r : x0_r,
                               cmd.corner[1] ? y1_r : y0_r,
                               cmd.corner[2] ? z1_r : z0_r);

  assign out_ghost_value  = out_ghost_r;
  assign out_mirror_value = out_mirror_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ix_r     <= in_index_x;
      iy_r     <= in_index_y;
      iz_r     <= in_index_z;
      sample_r <= in_sample;
      mx_r     <= in_pos_x;
      my_r     <= in_pos_y;
      mz_r     <= in_pos_z;
      dist_r   <= in_distance;
    end
    if (cmd.calc_idx) begin
      x0_r   <= clamp_idx(ix0, nx);
      x1_r   <= clamp_idx(ix0 + I_W'(1), nx);
      y0_r   <= clamp_idx(iy0, ny);
      y1_r   <= clamp_idx(iy0 + I_W'(1), ny);
      z0_r   <= clamp_idx(iz0, nz);
      z1_r   <= clamp_idx(iz0 + I_W'(1), nz);
      sx_r   <= gx[FRAC_W-1:0];
      sy_r   <= gy[FRAC_W-1:0];
      sz_r   <= gz[FRAC_W-1:0];
      prod_r <= 64'(cfg.level) * $signed({33'd0, dist_r});
    end
    if (cmd.capture) begin
      for (int i = 0; i < 7; i++) cq_r[i] <= cq_r[i+1];
      cq_r[7] <= ram_rdata;
    end
    if (cmd.lerp_en) begin
      if (cmd.step < 3'd4) begin
        // drop the consumed pair, append the x result
        for (int i = 0; i < 6; i++) cq_r[i] <= cq_r[i+2];
        for (int i = 0; i < 3; i++) vq_r[i] <= vq_r[i+1];
        vq_r[3] <= lres;
      end else if (cmd.step < 3'd6) begin
        vq_r[0] <= vq_r[2];
        vq_r[1] <= vq_r[3];
        dq_r[0] <= dq_r[1];
        dq_r[1] <= lres;
      end else begin
        mirror_r <= lres;
      end
    end
    if (cmd.final_en) begin
      ghost_r <= gsat;
    end
    if (cmd.push_out) begin
      out_ghost_r  <= ghost_r;
      out_mirror_r <= mirror_r;
    end
  end
endmodule
`default_nettype wire

// File: hdl/ghost_cell_mirror_interpolation_top.sv
// Ghost-cell corrector over a 64x64x64 grid of Q16.16 samples.
// in_ch (valid/ready) carries one request: mode 0 stores sample at the
// index, mode 1 interpolates trilinearly at the Q12.12 mirror point,
// applies the Dirichlet or Neumann rule, writes the ghost value back at
// the index and emits ghost_value and mirror_value on out_ch.
// One request is worked on at a time. A write request stores its sample.
// A correct request runs the index step, the eight corner reads through
// the single read port of the grid memory, the x, y and z interpolations
// on the shared interpolation multiplier, the boundary rule and the
// write-back; the next request is taken only once the block is idle.
// The output register lets a new request enter while a result waits;
// a finished result stalls in place while out_ch.ready is low.
// Registers sit on the APB-style cfg_ port at byte address 4*i; the user
// must write them only while the block is idle, which the block does
// not enforce. Synchronous reset clears control and registers but sets
// the cell counts to 64; grid contents are undefined until written.
`default_nettype none
module ghost_cell_mirror_interpolation_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gcmi_in_if.sink                    in_ch,
  gcmi_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [gcmi_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);
  import gcmi_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  gcmi_cfg u_cfg (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg(cfg)
  );

  gcmi_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_mode(in_ch.mode), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd)
  );

  gcmi_dp u_dp (
    .clk, .cmd(cmd), .cfg(cfg),
    .in_index_x(in_ch.index_x), .in_index_y(in_ch.index_y),
    .in_index_z(in_ch.index_z), .in_sample(in_ch.sample),
    .in_pos_x(in_ch.pos_x), .in_pos_y(in_ch.pos_y),
    .in_pos_z(in_ch.pos_z), .in_distance(in_ch.distance),
    .ram_we, .ram_waddr, .ram_wdata, .ram_re, .ram_raddr, .ram_rdata,
    .out_ghost_value(out_ch.ghost_value), .out_mirror_value(out_ch.mirror_value)
  );

  gcmi_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_grid (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule
`default_nettype wire

// File: hdl/gcmi_chk.sv
`default_nettype none
module gcmi_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_mode,
  input wire logic out_valid,
  input wire logic out_ready
);
  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second request taken");

  // a store request makes no result
  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> ##1 !$rose(out_valid))
    else $error("result after store");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind ghost_cell_mirror_interpolation_top gcmi_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
